>>> sv/utf8_codepoint_decoder_top_assert.svh
// Assertion macros for the UTF-8 decoder checker.
// Expects signals named clock and reset in the scope of use.
`ifndef UTF8_CODEPOINT_DECODER_TOP_ASSERT_SVH
`define UTF8_CODEPOINT_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define U8DEC_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("u8dec assertion failed: %m");

// Next-cycle implication, disabled during reset.
`define U8DEC_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("u8dec assertion failed: %m");

`endif

>>> sv/u8dec_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the UTF-8 code point decoder.
// No dependencies.
package u8dec_pkg;

   localparam int BYTE_W    = 8;
   localparam int CP_W      = 21;
   localparam int BUF_DEPTH = 4;
   localparam int CNT_W     = 3;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [CP_W-1:0]   cp_type;
   typedef logic [CNT_W-1:0]  cnt_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   localparam cp_type REPLACEMENT_CP = 21'h00FFFD;
   localparam cp_type MAX_CP         = 21'h10FFFF;
   localparam cp_type SURR_LO        = 21'h00D800;
   localparam cp_type SURR_HI        = 21'h00DFFF;
   localparam cp_type MIN_CP2        = 21'h000080;
   localparam cp_type MIN_CP3        = 21'h000800;
   localparam cp_type MIN_CP4        = 21'h010000;

   localparam byte_type CONT_MASK  = 8'hC0;
   localparam byte_type CONT_TAG   = 8'h80;
   localparam byte_type LEAD2_MASK = 8'hE0;
   localparam byte_type LEAD2_TAG  = 8'hC0;
   localparam byte_type LEAD3_MASK = 8'hF0;
   localparam byte_type LEAD3_TAG  = 8'hE0;
   localparam byte_type LEAD4_MASK = 8'hF8;
   localparam byte_type LEAD4_TAG  = 8'hF0;

endpackage

>>> sv/u8dec_if.sv
`timescale 1ns / 1ps
// Valid/ready channels of the UTF-8 decoder: byte requests and code point responses.
// Depends on u8dec_pkg.
interface u8dec_req_if;
   logic               valid;
   logic               ready;
   u8dec_pkg::byte_type text_byte;
   logic               end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface u8dec_rsp_if;
   logic             valid;
   logic             ready;
   u8dec_pkg::cp_type code_point;
   logic             substituted;
   logic             last_of_text;

   modport source (output valid, output code_point, output substituted,
                   output last_of_text, input ready);
   modport sink (input valid, input code_point, input substituted,
                 input last_of_text, output ready);
endinterface

>>> sv/utf8_codepoint_decoder_top.sv
`timescale 1ns / 1ps
// UTF-8 decoder with U+FFFD replacement: one byte beat in, zero to four code points out.
// Depends on u8dec_pkg and the channel interfaces in u8dec_if.sv.
//
// Bytes of a string enter one beat at a time, the last one flagged end_of_text. A byte beat
// is taken only while the block is idle; a single check-and-shift unit then resolves one
// form from the head of a four-byte buffer per cycle while no response is held off by
// ready. A byte that only extends an unfinished form leaves it in the buffer for the next
// byte. Invalid leads, broken or overlong forms, surrogates, values above U+10FFFF and
// forms cut short by end_of_text each give U+FFFD with substituted set and consume one
// byte; the bytes behind it are scanned again.
// The result register lets a response wait while the next byte is accepted.
module utf8_codepoint_decoder_top (
   input  logic             clock,
   input  logic             reset,
   u8dec_req_if.sink        req_bus,
   u8dec_rsp_if.source      rsp_bus
);

   u8dec_pkg::state_type state_ff, state_in;
   u8dec_pkg::byte_type  buf_ff [u8dec_pkg::BUF_DEPTH];
   u8dec_pkg::byte_type  buf_in [u8dec_pkg::BUF_DEPTH];
   u8dec_pkg::cnt_type   cnt_ff, cnt_in;
   logic                 end_ff, end_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   u8dec_pkg::cp_type    cp_ff, cp_in;
   logic                 sub_ff, sub_in;
   logic                 last_ff, last_in;

   // check unit signals
   u8dec_pkg::cnt_type   need;
   u8dec_pkg::cnt_type   take;
   logic                 c1, c2, c3;
   logic                 ok2, ok3, ok4;
   logic                 ok, short_form, stall;
   u8dec_pkg::cp_type    v2, v3, v4, cp_ok;
   logic [u8dec_pkg::BUF_DEPTH*u8dec_pkg::BYTE_W-1:0] flat, shifted;

   always_comb begin
      c1 = (buf_ff[1] & u8dec_pkg::CONT_MASK) == u8dec_pkg::CONT_TAG;
      c2 = (buf_ff[2] & u8dec_pkg::CONT_MASK) == u8dec_pkg::CONT_TAG;
      c3 = (buf_ff[3] & u8dec_pkg::CONT_MASK) == u8dec_pkg::CONT_TAG;

      if (!buf_ff[0][7]) begin
         need = 3'd1;
      end else if ((buf_ff[0] & u8dec_pkg::LEAD2_MASK) == u8dec_pkg::LEAD2_TAG) begin
         need = 3'd2;
      end else if ((buf_ff[0] & u8dec_pkg::LEAD3_MASK) == u8dec_pkg::LEAD3_TAG) begin
         need = 3'd3;
      end else if ((buf_ff[0] & u8dec_pkg::LEAD4_MASK) == u8dec_pkg::LEAD4_TAG) begin
         need = 3'd4;
      end else begin
         need = 3'd0;
      end

      v2 = {10'd0, buf_ff[0][4:0], buf_ff[1][5:0]};
      v3 = {5'd0, buf_ff[0][3:0], buf_ff[1][5:0], buf_ff[2][5:0]};
      v4 = {buf_ff[0][2:0], buf_ff[1][5:0], buf_ff[2][5:0], buf_ff[3][5:0]};

      ok2 = c1 && (v2 >= u8dec_pkg::MIN_CP2);
      ok3 = c1 && c2 && (v3 >= u8dec_pkg::MIN_CP3) &&
            !((v3 >= u8dec_pkg::SURR_LO) && (v3 <= u8dec_pkg::SURR_HI));
      ok4 = c1 && c2 && c3 && (v4 >= u8dec_pkg::MIN_CP4) && (v4 <= u8dec_pkg::MAX_CP);

      short_form = need > cnt_ff;
      stall      = short_form && !end_ff;

      case (need)
         3'd1:    begin ok = 1'b1; cp_ok = {13'd0, buf_ff[0]}; end
         3'd2:    begin ok = ok2;  cp_ok = v2; end
         3'd3:    begin ok = ok3;  cp_ok = v3; end
         3'd4:    begin ok = ok4;  cp_ok = v4; end
         default: begin ok = 1'b0; cp_ok = u8dec_pkg::REPLACEMENT_CP; end
      endcase
      ok   = ok && !short_form;
      take = ok ? need : 3'd1;

      // drop the consumed bytes from the head of the buffer
      flat    = {buf_ff[3], buf_ff[2], buf_ff[1], buf_ff[0]};
      shifted = flat >> {take, 3'b000};
   end

   always_comb begin
      state_in     = state_ff;
      buf_in       = buf_ff;
      cnt_in       = cnt_ff;
      end_in       = end_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      cp_in        = cp_ff;
      sub_in       = sub_ff;
      last_in      = last_ff;

      unique case (state_ff)
         u8dec_pkg::ST_IDLE: begin
            if (req_bus.valid) begin
               buf_in[cnt_ff[1:0]] = req_bus.text_byte;
               cnt_in   = cnt_ff + 3'd1;
               end_in   = req_bus.end_of_text;
               state_in = u8dec_pkg::ST_SCAN;
            end
         end
         u8dec_pkg::ST_SCAN: begin
            if (stall) begin
               // hold the unfinished form for the next byte
               state_in = u8dec_pkg::ST_IDLE;
            end else if (!rsp_valid_ff || rsp_bus.ready) begin
               for (int i = 0; i < u8dec_pkg::BUF_DEPTH; i++) begin
                  buf_in[i] = shifted[i*u8dec_pkg::BYTE_W +: u8dec_pkg::BYTE_W];
               end
               cnt_in       = cnt_ff - take;
               rsp_valid_in = 1'b1;
               cp_in        = ok ? cp_ok : u8dec_pkg::REPLACEMENT_CP;
               sub_in       = !ok;
               last_in      = end_ff && (take == cnt_ff);
               if (take == cnt_ff) begin
                  state_in = u8dec_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = u8dec_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= u8dec_pkg::ST_IDLE;
         cnt_ff       <= '0;
         end_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         end_ff       <= end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff  <= buf_in;
      cp_ff   <= cp_in;
      sub_ff  <= sub_in;
      last_ff <= last_in;
   end

   assign req_bus.ready        = (state_ff == u8dec_pkg::ST_IDLE);
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.code_point   = cp_ff;
   assign rsp_bus.substituted  = sub_ff;
   assign rsp_bus.last_of_text = last_ff;

endmodule

>>> sv/u8dec_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the UTF-8 decoder, bound to the top level.
// Depends on u8dec_pkg and utf8_codepoint_decoder_top_assert.svh.
`include "utf8_codepoint_decoder_top_assert.svh"

module u8dec_port_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input u8dec_pkg::cp_type code_point,
   input logic              substituted,
   input logic              last_of_text
);

   logic [u8dec_pkg::CP_W+1:0] rsp_payload;
   logic                       cp_is_scalar;

   assign rsp_payload  = {code_point, substituted, last_of_text};
   assign cp_is_scalar = (code_point <= u8dec_pkg::MAX_CP) &&
                         !((code_point >= u8dec_pkg::SURR_LO) &&
                           (code_point <= u8dec_pkg::SURR_HI));

   // a replacement beat always carries U+FFFD
   `U8DEC_ASSERT_NOW(a_sub_is_fffd, rsp_valid && substituted, code_point == u8dec_pkg::REPLACEMENT_CP)

   // every beat is a Unicode scalar value
   `U8DEC_ASSERT_NOW(a_scalar_range, rsp_valid, cp_is_scalar)

   // a taken byte moves the block into its scan state, so it is not ready for another byte
   `U8DEC_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready)

   // a stalled response holds
   `U8DEC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

endmodule

bind utf8_codepoint_decoder_top u8dec_port_checker u_u8dec_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .code_point   (rsp_bus.code_point),
   .substituted  (rsp_bus.substituted),
   .last_of_text (rsp_bus.last_of_text)
);
